[src/sha256_message_digest_assert.svh]
// assertion macros for the checker file sha256_message_digest_check
// expects signals clk and rst in the scope of use
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// implication checked in the same cycle
`define SHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition in the cycle after reset
`define SHA_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

[src/sha256_pkg.sv]
// sha256 package: command type, state encoding, constants and round functions
// no dependencies
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic       has_byte;
    logic       is_end;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastPos  = 6'd63;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[src/sha256_if.sv]
// channel interfaces for the message byte input and the digest word output
// no dependencies
interface sha256_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       message_end;

  modport source(output valid, message_byte, byte_present, message_end, input ready);
  modport sink(input valid, message_byte, byte_present, message_end, output ready);
endinterface

interface sha256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

[src/sha256_front.sv]
// input side: takes message items, drops idle items, pushes commands into the queue
// depends on sha256_pkg and sha256_msg_if
module sha256_front (
  sha256_msg_if.sink          msg,
  input  logic                full,
  output logic                push,
  output sha256_pkg::cmd_t    push_data
);

  assign msg.ready = !full;

  // an item with neither a byte nor an end marker carries no work
  assign push = msg.valid && !full && (msg.byte_present || msg.message_end);

  always_comb begin
    push_data.has_byte = msg.byte_present;
    push_data.is_end   = msg.message_end;
    push_data.data     = msg.message_byte;
  end

endmodule

[src/sha256_queue.sv]
// short command queue between the front and the hash core
// depends on sha256_pkg
module sha256_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sha256_pkg::cmd_t push_data,
  output logic             full,
  input  logic             pop,
  output sha256_pkg::cmd_t pop_data,
  output logic             not_empty
);

  sha256_pkg::cmd_t mem [sha256_pkg::QueueDepth];
  logic [sha256_pkg::QueueAw-1:0] wr_ptr;
  logic [sha256_pkg::QueueAw-1:0] rd_ptr;
  logic [sha256_pkg::QueueAw:0]   count;
  logic do_push;
  logic do_pop;

  assign full      = (count == (sha256_pkg::QueueAw+1)'(sha256_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/sha256_core.sv]
// hash core: packs bytes, pads, runs one compression round per cycle, emits digest
// depends on sha256_pkg and sha256_dig_if
module sha256_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  sha256_pkg::cmd_t cmd,
  output logic             cmd_pop,
  sha256_dig_if.source     digest
);

  sha256_pkg::state_t state;
  sha256_pkg::state_t state_next;

  logic [511:0] blk;
  logic [5:0]   pos;
  logic [63:0]  len;
  logic [5:0]   rnd;
  logic [2:0]   ocnt;
  logic [31:0]  cv [8];
  logic [31:0]  v  [8];
  logic         padding;
  logic         did80;
  logic         extra;
  logic         done;

  logic [31:0] w_t;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [7:0]  pad_byte;
  logic        pad_extra_next;
  logic        pad_done_next;
  logic        blk_full;

  // window taps: word i of the 16-word schedule window
  assign w_t   = blk[511:480];
  assign w_new = sha256_pkg::ssig1(blk[63:32]) + blk[223:192]
               + sha256_pkg::ssig0(blk[479:448]) + blk[511:480];

  assign t1 = v[7] + sha256_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + sha256_pkg::K[rnd] + w_t;
  assign t2 = sha256_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign blk_full = (pos == sha256_pkg::LastPos);

  // padding byte: 0x80, zeros, then the big-endian bit length at the block tail
  always_comb begin
    pad_extra_next = extra;
    pad_done_next  = done;
    if (!did80) begin
      pad_byte       = sha256_pkg::PadByte;
      pad_extra_next = (pos >= sha256_pkg::LenStart) && !blk_full;
    end else if (extra) begin
      pad_byte = 8'h00;
      if (blk_full) begin
        pad_extra_next = 1'b0;
      end
    end else if (pos >= sha256_pkg::LenStart) begin
      pad_byte = len[{~pos[2:0], 3'b000} +: 8];
      if (blk_full) begin
        pad_done_next = 1'b1;
      end
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.has_byte && blk_full) begin
            state_next = sha256_pkg::ST_ROUND;
          end else if (cmd.is_end) begin
            state_next = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (blk_full) begin
          state_next = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        if (done) begin
          state_next = sha256_pkg::ST_OUT;
        end else if (padding) begin
          state_next = sha256_pkg::ST_PAD;
        end else begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (digest.ready && ocnt == 3'd7) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop            = (state == sha256_pkg::ST_IDLE);
    digest.valid       = (state == sha256_pkg::ST_OUT);
    digest.digest_word = cv[ocnt];
    digest.word_index  = ocnt;
    digest.last_word   = (ocnt == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sha256_pkg::ST_IDLE;
      pos     <= '0;
      len     <= '0;
      rnd     <= '0;
      ocnt    <= '0;
      padding <= 1'b0;
      did80   <= 1'b0;
      extra   <= 1'b0;
      done    <= 1'b0;
      cv      <= sha256_pkg::IV;
    end else begin
      state <= state_next;
      if (state_next == sha256_pkg::ST_ROUND && state != sha256_pkg::ST_ROUND) begin
        v   <= cv;
        rnd <= '0;
      end
      case (state)
        sha256_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.has_byte) begin
              blk <= {blk[503:0], cmd.data};
              pos <= pos + 1'b1;
              len <= len + 64'd8;
            end
            if (cmd.is_end) begin
              padding <= 1'b1;
              did80   <= 1'b0;
              extra   <= 1'b0;
              done    <= 1'b0;
            end
          end
        end
        sha256_pkg::ST_PAD: begin
          blk   <= {blk[503:0], pad_byte};
          pos   <= pos + 1'b1;
          did80 <= 1'b1;
          extra <= pad_extra_next;
          done  <= pad_done_next;
        end
        sha256_pkg::ST_ROUND: begin
          blk  <= {blk[479:0], w_new};
          rnd  <= rnd + 1'b1;
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
        end
        sha256_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            cv[i] <= cv[i] + v[i];
          end
        end
        sha256_pkg::ST_OUT: begin
          if (digest.ready) begin
            ocnt <= ocnt + 1'b1;
            if (ocnt == 3'd7) begin
              cv      <= sha256_pkg::IV;
              len     <= '0;
              pos     <= '0;
              padding <= 1'b0;
              done    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[src/sha256_message_digest.sv]
// SHA-256 digest of a byte stream: the msg channel takes one item per transfer
// (message_byte, byte_present, message_end); the digest channel gives eight
// transfers (digest_word, word_index, last_word), word 0 first, last_word on word 7.
// Items pass through a four-entry command queue, so msg stays ready while the
// core compresses a block or waits on a stalled digest receiver, until the
// queue is full. Idle items are taken and dropped.
// Bytes leave the queue only while the core is idle. Each full 64-byte block runs
// 64 rounds on one shared round unit, then one add into the chaining value.
// End of message: padding goes at one byte per cycle, up to 72 bytes over one
// or two blocks, each block compressed when full, then the eight digest words,
// one per cycle when the receiver is ready; a stalled receiver holds the current word.
// Reset clears the queue, the counters and the length, and loads the initial
// hash value; msg is ready in the first cycle after reset falls.
// depends on sha256_pkg, sha256_if, sha256_front, sha256_queue, sha256_core
module sha256_message_digest (
  input  logic         clk,
  input  logic         rst,
  sha256_msg_if.sink   msg,
  sha256_dig_if.source digest
);

  logic             push;
  logic             full;
  logic             pop;
  logic             not_empty;
  sha256_pkg::cmd_t push_data;
  sha256_pkg::cmd_t pop_data;

  sha256_front u_front (
    .msg       (msg),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  sha256_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  sha256_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (not_empty),
    .cmd       (pop_data),
    .cmd_pop   (pop),
    .digest    (digest)
  );

endmodule

[src/sha256_message_digest_check.sv]
// port checker for sha256_message_digest, attached by bind
// depends on sha256_message_digest_assert.svh
`include "sha256_message_digest_assert.svh"

module sha256_message_digest_check (
  input logic        clk,
  input logic        rst,
  input logic        msg_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  `SHA_ASSERT_RST(a_reset_quiet, !out_valid && msg_ready, "digest valid or input not ready after reset")
  `SHA_ASSERT_SAME(a_last_flag, out_valid, last_word == (word_index == 3'd7), "last_word does not match word_index")
  `SHA_ASSERT_NEXT(a_word_order, out_valid && out_ready && !last_word, !out_valid || word_index == 3'($past(word_index) + 3'd1), "digest words out of order")
  `SHA_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index), "stalled digest word changed")

endmodule

bind sha256_message_digest sha256_message_digest_check u_check (
  .clk         (clk),
  .rst         (rst),
  .msg_ready   (msg.ready),
  .out_valid   (digest.valid),
  .out_ready   (digest.ready),
  .digest_word (digest.digest_word),
  .word_index  (digest.word_index),
  .last_word   (digest.last_word)
);

[tb/tb_sha256_message_digest.sv]
// testbench for sha256_message_digest: byte stream in, eight digest words out per message
// holds its own SHA-256 predictor; depends on sha256_pkg, sha256_if and the block itself
`timescale 1ns / 1ps

module tb_sha256_message_digest;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  logic clk;
  logic rst;

  sha256_msg_if msg_ch();
  sha256_dig_if dig_ch();

  sha256_message_digest u_dut (
    .clk(clk),
    .rst(rst),
    .msg(msg_ch),
    .digest(dig_ch)
  );

  msg_item_t    pending_items[$];
  digest_item_t expected_words[$];
  int           errors;
  int           src_idle;
  int           sink_stall;
  int           hold_req;
  int           hold_seen;
  int           hold_cnt;
  logic         msg_taken;
  int unsigned  quiet_cycles;

  // predictor state
  logic [31:0] hash_st[8];
  logic [31:0] block_words[16];
  logic [5:0]  fill_pos;
  logic [63:0] bit_len;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void reset_digest_state();
    for (int i = 0; i < 8; i++) hash_st[i] = sha256_pkg::IV[i];
    fill_pos = '0;
    bit_len  = '0;
  endfunction

  function void compress_block();
    logic [31:0] sched[64];
    logic [31:0] v[8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int t = 0; t < 16; t++) sched[t] = block_words[t];
    for (int t = 16; t < 64; t++) begin
      sched[t] = (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10))
               + sched[t-7]
               + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
               + sched[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K[t] + sched[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endfunction

  // big-endian packing; the first byte of a word clears it
  function void pack_byte(input logic [7:0] b);
    int sh;
    sh = (3 - fill_pos[1:0]) * 8;
    if (fill_pos[1:0] == 2'd0) block_words[fill_pos[5:2]] = 32'(b) << sh;
    else block_words[fill_pos[5:2]] |= 32'(b) << sh;
    fill_pos = fill_pos + 6'd1;
  endfunction

  function void absorb_item(input msg_item_t it);
    digest_item_t d;
    if (it.present) begin
      pack_byte(it.data);
      bit_len += 64'd8;
      if (fill_pos == 6'd0) compress_block();
    end
    if (!it.last) return;
    pack_byte(sha256_pkg::PadByte);
    // length field does not fit: pad out and compress an extra block
    if (fill_pos > sha256_pkg::LenStart || fill_pos == 6'd0) begin
      while (fill_pos != 6'd0) pack_byte(8'h00);
      compress_block();
    end
    while (fill_pos != sha256_pkg::LenStart) pack_byte(8'h00);
    block_words[14] = bit_len[63:32];
    block_words[15] = bit_len[31:0];
    fill_pos = '0;
    compress_block();
    for (int k = 0; k < 8; k++) begin
      d.word = hash_st[k];
      d.idx  = 3'(k);
      d.last = (k == 7);
      expected_words = {expected_words, d};
    end
    reset_digest_state();
  endfunction

  always #4 clk = ~clk;

  // transfer monitor: predicts on msg, checks on digest
  always @(posedge clk) begin
    msg_item_t    it;
    digest_item_t got;
    digest_item_t want;
    msg_taken <= !rst && msg_ch.valid && msg_ch.ready;
    if (!rst) begin
      if (msg_ch.valid && msg_ch.ready) begin
        it.data    = msg_ch.message_byte;
        it.present = msg_ch.byte_present;
        it.last    = msg_ch.message_end;
        absorb_item(it);
      end
      if (dig_ch.valid && dig_ch.ready) begin
        got.word = dig_ch.digest_word;
        got.idx  = dig_ch.word_index;
        got.last = dig_ch.last_word;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, got.word, got.idx);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.word !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time, want.word, got.word);
            errors++;
          end
          if (got.idx !== want.idx) begin
            $display("%0t: word_index expected %0d actual %0d", $time, want.idx, got.idx);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_word expected %b actual %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // sender: holds an item until its transfer, then maybe idles
  always @(negedge clk) begin
    msg_item_t it;
    logic      nxt_valid;
    if (rst) begin
      msg_ch.valid <= 1'b0;
    end else begin
      nxt_valid = msg_ch.valid && !msg_taken;
      if (!nxt_valid && pending_items.size() > 0 && $urandom_range(99) >= src_idle) begin
        it = pending_items.pop_front();
        msg_ch.message_byte <= it.data;
        msg_ch.byte_present <= it.present;
        msg_ch.message_end  <= it.last;
        nxt_valid = 1'b1;
      end
      msg_ch.valid <= nxt_valid;
    end
  end

  // receiver: random stalls plus a long hold-off on each request
  always @(negedge clk) begin
    if (rst) begin
      dig_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt  = HoldCycles;
      dig_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      dig_ch.ready <= 1'b0;
    end else begin
      dig_ch.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function void add_item(input logic [7:0] b, input logic p, input logic e);
    msg_item_t it;
    it.data = b; it.present = p; it.last = e;
    pending_items = {pending_items, it};
  endfunction

  // one random message; returns the number of items queued, idle items not counted
  function int add_message();
    int len;
    int n;
    logic [2:0] pick;
    logic together;
    pick = 3'($urandom_range(7));
    len = (pick == 3'd0) ? $urandom_range(54, 66)
        : (pick == 3'd1) ? $urandom_range(118, 129) : $urandom_range(0, 20);
    together = (len > 0) && $urandom_range(1);
    n = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_item(8'($urandom), 1'b1, together && (i == len - 1));
      n++;
    end
    if (!together) begin
      add_item(8'($urandom), 1'b0, 1'b1);
      n++;
    end
    return n;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
    int n;
    src_idle   = idle_pct;
    sink_stall = stall_pct;
    n = 0;
    while (n < items) n += add_message();
    wait (pending_items.size() == 0 && expected_words.size() == 0 && !msg_ch.valid);
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    src_idle = 0;
    sink_stall = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    msg_taken = 1'b0;
    msg_ch.valid = 1'b0;
    msg_ch.message_byte = '0;
    msg_ch.byte_present = 1'b0;
    msg_ch.message_end = 1'b0;
    dig_ch.ready = 1'b0;
    reset_digest_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty message, "abc", idle items, extreme bytes, bare end after bytes
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    // long receiver hold-off while the sender keeps offering
    hold_req++;
    run_phase(0, 0, 15);
    run_phase(56, 0, 15);
    run_phase(0, 56, 15);
    run_phase(31, 31, 15);

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_words.size() != 0)
        $display("%0t: %0d digest words never arrived", $time, expected_words.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
